/* rtl/sitda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// State encoding, controller/datapath command and status bundles, character
// codes and the decimal power table used by the digit extractor.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_W = 16;
  localparam int MAG_W   = 17;
  localparam int POS_W   = 3;
  localparam int DIG_W   = 4;
  localparam int CHAR_W  = 6;
  localparam int RADIX   = 10;

  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_neg;
    logic pos_zero;
  } sts_t;

  // Decimal weight of digit position pos (0 is units)
  function automatic logic [MAG_W-1:0] pow_of(input logic [POS_W-1:0] pos);
    logic [MAG_W-1:0] p;
    case (pos)
      3'd0:    p = MAG_W'(1);
      3'd1:    p = MAG_W'(10);
      3'd2:    p = MAG_W'(100);
      3'd3:    p = MAG_W'(1000);
      3'd4:    p = MAG_W'(10000);
      default: p = MAG_W'(1);
    endcase
    return p;
  endfunction

endpackage

/* rtl/sitda_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_datapath: magnitude, digit extraction and character register
// Holds the running remainder and digit position, picks one decimal digit
// per emit_digit cycle by a bank of compares against multiples of the weight.
// ----------------------------------------------------------------------------
module sitda_datapath (
  input  logic                             clk,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value,
  input  sitda_pkg::cmd_t                  cmd,
  output sitda_pkg::sts_t                  sts,
  output logic [sitda_pkg::CHAR_W-1:0]     ascii_char,
  output logic                             last_char
);
  import sitda_pkg::*;

  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] pos;

  logic [MAG_W-1:0] load_mag;
  logic [POS_W-1:0] load_pos;
  logic [MAG_W-1:0] weight;
  logic [MAG_W-1:0] mult [RADIX];
  logic [DIG_W-1:0] digit;
  logic [MAG_W-1:0] rem;

  // Form the 17-bit magnitude and its leading digit position at load
  always_comb begin
    if (value[VALUE_W-1]) begin
      load_mag = MAG_W'(MAG_W'(1) << VALUE_W) - {1'b0, value};
    end else begin
      load_mag = {1'b0, value};
    end
    if (load_mag >= MAG_W'(10000)) begin
      load_pos = POS_W'(4);
    end else if (load_mag >= MAG_W'(1000)) begin
      load_pos = POS_W'(3);
    end else if (load_mag >= MAG_W'(100)) begin
      load_pos = POS_W'(2);
    end else if (load_mag >= MAG_W'(10)) begin
      load_pos = POS_W'(1);
    end else begin
      load_pos = POS_W'(0);
    end
  end

  // Pick the current digit: count the multiples of the weight that fit
  always_comb begin
    weight = pow_of(pos);
    digit  = '0;
    for (int k = 0; k < RADIX; k++) begin
      mult[k] = MAG_W'(weight * MAG_W'(k));
    end
    for (int k = 1; k < RADIX; k++) begin
      digit = digit + DIG_W'(mag >= mult[k]);
    end
    rem = mag - mult[digit];
  end

  assign sts.in_neg   = value[VALUE_W-1];
  assign sts.pos_zero = (pos == '0);

  // Load a new magnitude or advance to the next digit position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= load_mag;
      pos <= load_pos;
    end else if (cmd.emit_digit) begin
      mag <= rem;
      pos <= pos - POS_W'(1);
    end
  end

  // Hold the character offered on the output channel
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      ascii_char <= CH_MINUS;
      last_char  <= 1'b0;
    end else if (cmd.emit_digit) begin
      ascii_char <= CH_ZERO + CHAR_W'(digit);
      last_char  <= (pos == '0);
    end
  end

endmodule

/* rtl/sitda_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_ctrl: conversion sequencer
// Accepts a request, emits the sign if needed, then one digit per free
// output slot; takes the next request while the last digit goes out.
// ----------------------------------------------------------------------------
module sitda_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            char_valid,
  input  logic            char_ready,
  input  sitda_pkg::sts_t sts,
  output sitda_pkg::cmd_t cmd
);
  import sitda_pkg::*;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   can_emit;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    can_emit   = !out_valid || char_ready;
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (can_emit) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (can_emit) begin
          cmd.emit_digit = 1'b1;
          if (sts.pos_zero) begin
            req_ready = 1'b1;
            if (req_valid) begin
              cmd.load   = 1'b1;
              state_next = sts.in_neg ? ST_SIGN : ST_DIGIT;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_next = 1'b1;
    end else if (char_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign char_valid = out_valid;

  // Never overwrite a character that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid || char_ready))
    else $error("character emitted into a full output register");

  // Load only when idle or on the final digit
  a_load_when: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == ST_IDLE || (state == ST_DIGIT && sts.pos_zero)))
    else $error("load while a conversion is in progress");

  // A negative request goes through the sign state
  a_sign_path: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> ((state == ST_SIGN) == $past(sts.in_neg)))
    else $error("sign state does not follow request sign");

  // Sign and digit never share a cycle
  a_one_char: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_sign && cmd.emit_digit))
    else $error("sign and digit emitted together");

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 16-bit integer to decimal ASCII text
// Usage:
//   Request channel (req_valid/req_ready, value) takes one signed integer.
//   Character channel (char_valid/char_ready, ascii_char, last_char) returns
//   its text most significant first: a minus sign for negative values, then
//   the digits with leading zeros suppressed; last_char marks the final one.
//   -32768 is converted through a 17-bit magnitude and gives "-32768".
// Timing:
//   A request is loaded into the magnitude and state registers, then the
//   first character into the output register; one character follows per
//   cycle while the receiver takes them. A number gives 1 to 6 characters;
//   requests may follow back to back, since the next request is taken with
//   the final digit. The digit sequencer takes one digit per cycle from a
//   compare bank on the running remainder.
// Reset and stall:
//   Synchronous reset drops any conversion in progress and empties the
//   output register. While char_ready is low the offered character holds
//   and the sequencer waits; no request is taken until the last digit moves.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value,
  output logic                                 char_valid,
  input  logic                                 char_ready,
  output logic [sitda_pkg::CHAR_W-1:0]         ascii_char,
  output logic                                 last_char
);
  import sitda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  sitda_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Magnitude and digit datapath
  sitda_datapath u_datapath (
    .clk        (clk),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule

/* sim/signed_int_to_decimal_ascii_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test: decimal text conversion testbench
// Sends signed 16-bit requests and checks every returned character and its
// last flag against typed-in text or an in-bench predictor. A short table
// covers zero, the extremes, single digits, powers of ten and inner zeros;
// random requests follow under three idle profiles on both channels.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;
  import sitda_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 10;
  localparam int PHASE_ITEMS  = 170;
  localparam int NUM_DIR_ROWS = 22;
  localparam int MAX_DIGITS   = 5;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  typedef struct {
    logic signed [VALUE_W-1:0] val;
    string                     text;
  } dir_row_t;

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_ready;
  logic signed [VALUE_W-1:0] value;
  logic                      char_valid;
  logic                      char_ready = 1'b0;
  logic [CHAR_W-1:0]         ascii_char;
  logic                      last_char;

  text_char_t expected_chars[$];
  int         fail_count = 0;
  int         stall_cycles = 0;
  int         tx_idle_pct;
  int         rx_idle_pct;

  // Empty text means the row is checked against the predictor
  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{16'sd0,      "0"},
    '{16'sh7FFF,   "32767"},
    '{16'sh8000,   "-32768"},
    '{16'shFFFF,   "-1"},
    '{16'sd1,      "1"},
    '{16'sd9,      ""},
    '{16'sd10,     ""},
    '{-16'sd9,     ""},
    '{-16'sd10,    ""},
    '{16'sd99,     ""},
    '{16'sd100,    ""},
    '{16'sd999,    ""},
    '{16'sd1000,   ""},
    '{16'sd9999,   ""},
    '{16'sd10000,  ""},
    '{-16'sd10000, ""},
    '{-16'sd32767, ""},
    '{16'sd12345,  ""},
    '{16'sh5555,   ""},
    '{16'shAAAA,   ""},
    '{16'sd10001,  ""},
    '{-16'sd30000, ""}
  };

  signed_int_to_decimal_ascii u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .value      (value),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predict the decimal text of one value and queue its characters
  function automatic void push_decimal_text(input logic signed [VALUE_W-1:0] v);
    logic [MAG_W-1:0] mag;
    logic [DIG_W-1:0] digits [MAX_DIGITS];
    int               n_digits;
    mag      = v[VALUE_W-1] ? (MAG_W'(17'h10000) - MAG_W'({1'b0, v})) : MAG_W'({1'b0, v});
    n_digits = 0;
    do begin
      digits[n_digits] = DIG_W'(mag % RADIX);
      mag              = MAG_W'(mag / RADIX);
      n_digits++;
    end while (mag != 0 && n_digits < MAX_DIGITS);
    if (v[VALUE_W-1])
      expected_chars.push_back('{ch: CH_MINUS, last: 1'b0});
    for (int d = n_digits - 1; d >= 0; d--)
      expected_chars.push_back('{ch: CH_ZERO + CHAR_W'(digits[d]), last: (d == 0)});
  endfunction

  // Queue a typed-in text as the expected characters
  function automatic void push_typed_text(input string text);
    for (int i = 0; i < text.len(); i++)
      expected_chars.push_back('{ch: CHAR_W'(text[i]), last: (i == text.len() - 1)});
  endfunction

  // Offer one request, hold it until taken, then queue what it must produce
  task automatic send_request(input logic signed [VALUE_W-1:0] v, input string text);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    req_valid <= 1'b1;
    value     <= v;
    do @(posedge clk); while (!req_ready);
    if (text.len() == 0)
      push_decimal_text(v);
    else
      push_typed_text(text);
  endtask

  // Pick a random value: full range, small magnitudes or near powers of ten
  function automatic logic signed [VALUE_W-1:0] random_value();
    int mode;
    int pow;
    int v;
    mode = $urandom_range(9, 0);
    if (mode < 5) begin
      v = $urandom;
    end else if (mode < 8) begin
      v = int'($urandom_range(200, 0)) - 100;
    end else begin
      pow = 1;
      repeat ($urandom_range(4, 0)) pow = pow * 10;
      v = pow + int'($urandom_range(2, 0)) - 1;
      if ($urandom_range(1, 0) == 1)
        v = -v;
    end
    return VALUE_W'(v);
  endfunction

  // Randomly stall the character channel
  always @(posedge clk) begin
    char_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // Check each accepted character against the oldest expectation
  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst && char_valid && char_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: ascii_char %0d last_char %0b", ascii_char, last_char);
        fail_count++;
      end else begin
        exp_c = expected_chars.pop_front();
        if (ascii_char !== exp_c.ch) begin
          $error("ascii_char: expected %0d, actual %0d", exp_c.ch, ascii_char);
          fail_count++;
        end
        if (last_char !== exp_c.last) begin
          $error("last_char: expected %0b, actual %0b", exp_c.last, last_char);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (char_valid && char_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    tx_idle_pct  = 18;
    rx_idle_pct  = 56;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    value      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < NUM_DIR_ROWS; r++)
      send_request(dir_rows[r].val, dir_rows[r].text);

    // Random requests under three idle profiles
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 18 : (p == 1) ? 56 : 0;
      rx_idle_pct = (p == 0) ? 56 : (p == 1) ? 18 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_request(random_value(), "");
    end
    req_valid <= 1'b0;

    // Drain outstanding characters, then watch for strays
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sitda_pkg.sv
rtl/sitda_datapath.sv
rtl/sitda_ctrl.sv
rtl/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_test.sv
